[rtl/tape_machine_interpreter_unit_assert.svh]
// Assertion macros for the tape machine interpreter.
`ifndef TAPE_MACHINE_INTERPRETER_UNIT_ASSERT_SVH
`define TAPE_MACHINE_INTERPRETER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmi assertion failed");

// Next-cycle implication, checked outside reset.
`define TMI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmi assertion failed");

`endif

[rtl/tmi_pkg.sv]
// ----------------------------------------------------------------------------
// tmi_pkg
// Types, codes and sizes shared by the tape machine interpreter.
// ----------------------------------------------------------------------------
package tmi_pkg;

  localparam int PROG_DEPTH = 1024;
  localparam int TAPE_DEPTH = 1024;
  localparam int IN_DEPTH   = 256;
  localparam int PROG_AW    = $clog2(PROG_DEPTH);
  localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
  localparam int IN_AW      = $clog2(IN_DEPTH);
  localparam int RUN_BUDGET = 1048576;
  localparam int BUDGET_W   = $clog2(RUN_BUDGET) + 1;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_RUN  = 2'd2;

  localparam logic [2:0] OP_PTR_INC  = 3'd0;
  localparam logic [2:0] OP_PTR_DEC  = 3'd1;
  localparam logic [2:0] OP_CELL_INC = 3'd2;
  localparam logic [2:0] OP_CELL_DEC = 3'd3;
  localparam logic [2:0] OP_OUTPUT   = 3'd4;
  localparam logic [2:0] OP_INPUT    = 3'd5;
  localparam logic [2:0] OP_JMP_FWD  = 3'd6;
  localparam logic [2:0] OP_JMP_BACK = 3'd7;

  localparam logic [2:0] ST_BYTE      = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_UNM_FWD   = 3'd3;
  localparam logic [2:0] ST_UNM_BACK  = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_TAPE_FULL = 3'd6;

  localparam logic [7:0] NEWLINE = 8'd10;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

endpackage

[rtl/tmi_ram.sv]
// ----------------------------------------------------------------------------
// tmi_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tmi_ctrl.sv]
// ----------------------------------------------------------------------------
// tmi_ctrl
// Sequencer: program, tape and queue memories plus the instruction FSM.
// ----------------------------------------------------------------------------
module tmi_ctrl
  import tmi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      res_valid,
  output out_item_t res,
  input  logic      res_take
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_TLOAD = 4'd4;
  localparam logic [3:0] S_QWAIT = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_SCHK  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]          state, state_next;
  logic [PROG_AW:0]    plen, plen_next;
  logic [PROG_AW:0]    pc, pc_next;
  logic [PROG_AW:0]    sp, sp_next;
  logic                sdir, sdir_next;   // 1: scan backward
  logic [PROG_AW:0]    nest, nest_next;
  logic [TAPE_AW-1:0]  pos, pos_next;
  logic [TAPE_AW:0]    extent, extent_next;
  logic [IN_AW:0]      qr, qr_next;
  logic [IN_AW:0]      qw, qw_next;
  logic [BUDGET_W-1:0] budget, budget_next;
  logic [7:0]          cur, cur_next;     // mirror of tape[pos]
  out_item_t           res_next;

  logic               p_we;
  logic [PROG_AW-1:0] p_waddr, p_raddr;
  logic [2:0]         p_rdata;
  logic               t_we;
  logic [TAPE_AW-1:0] t_waddr, t_raddr;
  logic [7:0]         t_wdata, t_rdata;
  logic               q_we;
  logic [IN_AW-1:0]   q_raddr;
  logic [7:0]         q_rdata;
  logic [PROG_AW:0]   pc_inc, sp_inc;

  tmi_ram #(.WIDTH(3), .DEPTH(PROG_DEPTH)) u_prog (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(in_data.opcode),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  tmi_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  tmi_ram #(.WIDTH(8), .DEPTH(IN_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(qw[IN_AW-1:0]), .wdata(in_data.data_byte),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign pc_inc    = pc + 1'b1;
  assign sp_inc    = sp + 1'b1;

  always_comb begin
    state_next  = state;
    plen_next   = plen;
    pc_next     = pc;
    sp_next     = sp;
    sdir_next   = sdir;
    nest_next   = nest;
    pos_next    = pos;
    extent_next = extent;
    qr_next     = qr;
    qw_next     = qw;
    budget_next = budget;
    cur_next    = cur;
    res_next    = res;
    p_we        = 1'b0;
    p_waddr     = plen[PROG_AW-1:0];
    p_raddr     = pc[PROG_AW-1:0];
    t_we        = 1'b0;
    t_waddr     = pos;
    t_wdata     = cur;
    t_raddr     = pos;
    q_we        = 1'b0;
    q_raddr     = qr[IN_AW-1:0];

    unique case (state)
      S_INIT: begin
        t_we       = 1'b1;
        t_waddr    = '0;
        t_wdata    = '0;
        cur_next   = '0;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.req_type)
            REQ_LOAD: begin
              if (plen < (PROG_AW+1)'(PROG_DEPTH)) begin
                p_we      = 1'b1;
                plen_next = plen + 1'b1;
              end
            end
            REQ_DATA: begin
              if (qw < (IN_AW+1)'(IN_DEPTH)) begin
                q_we    = 1'b1;
                qw_next = qw + 1'b1;
              end
            end
            REQ_RUN: begin
              if (plen == '0) begin
                res_next   = '{out_byte: 8'd0, status: ST_EMPTY, last: 1'b1};
                state_next = S_EMIT;
              end else begin
                budget_next = '0;
                state_next  = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        if (pc >= plen) begin
          // program end: tape shrinks back to one zero cell
          t_we        = 1'b1;
          t_waddr     = '0;
          t_wdata     = '0;
          cur_next    = '0;
          pos_next    = '0;
          extent_next = (TAPE_AW+1)'(1);
          plen_next   = '0;
          pc_next     = '0;
          nest_next   = '0;
          qr_next     = '0;
          qw_next     = '0;
          res_next    = '{out_byte: NEWLINE, status: ST_DONE, last: 1'b1};
          state_next  = S_EMIT;
        end else if (budget == BUDGET_W'(RUN_BUDGET)) begin
          state_next = S_IDLE;
        end else begin
          budget_next = budget + 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FETCH;
        pc_next    = pc_inc;
        unique case (p_rdata) inside
          OP_PTR_INC: begin
            if ({1'b0, pos} + 1'b1 >= extent) begin
              if (extent == (TAPE_AW+1)'(TAPE_DEPTH)) begin
                plen_next  = '0;
                pc_next    = '0;
                nest_next  = '0;
                res_next   = '{out_byte: 8'd0, status: ST_TAPE_FULL, last: 1'b1};
                state_next = S_EMIT;
              end else begin
                t_we        = 1'b1;
                t_waddr     = extent[TAPE_AW-1:0];
                t_wdata     = '0;
                extent_next = extent + 1'b1;
                pos_next    = pos + 1'b1;
                cur_next    = '0;
              end
            end else begin
              pos_next   = pos + 1'b1;
              t_raddr    = pos + 1'b1;
              state_next = S_TLOAD;
            end
          end
          OP_PTR_DEC: begin
            if (pos == '0) begin
              plen_next  = '0;
              pc_next    = '0;
              nest_next  = '0;
              res_next   = '{out_byte: 8'd0, status: ST_UNDERFLOW, last: 1'b1};
              state_next = S_EMIT;
            end else begin
              pos_next   = pos - 1'b1;
              t_raddr    = pos - 1'b1;
              state_next = S_TLOAD;
            end
          end
          OP_CELL_INC: begin
            cur_next = cur + 1'b1;
            t_we     = 1'b1;
            t_wdata  = cur + 1'b1;
          end
          OP_CELL_DEC: begin
            cur_next = cur - 1'b1;
            t_we     = 1'b1;
            t_wdata  = cur - 1'b1;
          end
          OP_OUTPUT: begin
            res_next   = '{out_byte: cur, status: ST_BYTE, last: 1'b0};
            state_next = S_EMIT;
          end
          OP_INPUT: begin
            if (qr < qw) begin
              qr_next    = qr + 1'b1;
              pc_next    = pc;
              state_next = S_QWAIT;
            end
          end
          OP_JMP_FWD, OP_JMP_BACK: begin
            if ((p_rdata == OP_JMP_FWD) == (cur == 8'd0)) begin
              sp_next    = pc;
              sdir_next  = (p_rdata == OP_JMP_BACK);
              nest_next  = '0;
              pc_next    = pc;
              state_next = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_TLOAD: begin
        cur_next   = t_rdata;
        state_next = S_FETCH;
      end
      S_QWAIT: begin
        if (!is_space(q_rdata)) begin
          cur_next   = q_rdata;
          t_we       = 1'b1;
          t_wdata    = q_rdata;
          pc_next    = pc_inc;
          state_next = S_FETCH;
        end else if (qr < qw) begin
          qr_next = qr + 1'b1;
        end else begin
          pc_next    = pc_inc;
          state_next = S_FETCH;
        end
      end
      S_SCAN: begin
        if (!sdir) begin
          if (sp_inc >= plen) begin
            plen_next  = '0;
            pc_next    = '0;
            nest_next  = '0;
            res_next   = '{out_byte: 8'd0, status: ST_UNM_FWD, last: 1'b1};
            state_next = S_EMIT;
          end else begin
            sp_next    = sp_inc;
            p_raddr    = sp_inc[PROG_AW-1:0];
            state_next = S_SCHK;
          end
        end else begin
          if (sp == '0) begin
            plen_next  = '0;
            pc_next    = '0;
            nest_next  = '0;
            res_next   = '{out_byte: 8'd0, status: ST_UNM_BACK, last: 1'b1};
            state_next = S_EMIT;
          end else begin
            sp_next    = sp - 1'b1;
            p_raddr    = PROG_AW'(sp - 1'b1);
            state_next = S_SCHK;
          end
        end
      end
      S_SCHK: begin
        state_next = S_SCAN;
        // closing code for this direction ends the scan at depth zero
        if (p_rdata == (sdir ? OP_JMP_FWD : OP_JMP_BACK)) begin
          if (nest == '0) begin
            pc_next    = sp_inc;
            state_next = S_FETCH;
          end else begin
            nest_next = nest - 1'b1;
          end
        end else if (p_rdata == (sdir ? OP_JMP_BACK : OP_JMP_FWD)) begin
          nest_next = nest + 1'b1;
        end
      end
      S_EMIT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      plen   <= '0;
      pc     <= '0;
      nest   <= '0;
      pos    <= '0;
      extent <= (TAPE_AW+1)'(1);
      qr     <= '0;
      qw     <= '0;
    end else begin
      state  <= state_next;
      plen   <= plen_next;
      pc     <= pc_next;
      nest   <= nest_next;
      pos    <= pos_next;
      extent <= extent_next;
      qr     <= qr_next;
      qw     <= qw_next;
    end
    sp     <= sp_next;
    sdir   <= sdir_next;
    budget <= budget_next;
    cur    <= cur_next;
    res    <= res_next;
  end

endmodule

[rtl/tmi_oreg.sv]
// ----------------------------------------------------------------------------
// tmi_oreg
// Output register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module tmi_oreg
  import tmi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  input  out_item_t res,
  output logic      res_take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

[rtl/tape_machine_interpreter_unit.sv]
// ----------------------------------------------------------------------------
// tape_machine_interpreter_unit
// Eight-instruction tape machine with program, tape and input queue RAMs.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): load items append an opcode to
// program RAM or a byte to the input queue while there is room. A run item
// executes from the saved program counter until an output instruction, the
// program end (newline result, state cleared) or an error, giving one result.
// Run steps: a fetch and an execute state per instruction, a tape load state
// for a pointer move that reads the tape, a queue wait state per byte popped,
// a scan and a check state per program word visited during a bracket scan,
// then an emit state to hand over the result. All work runs in one FSM.
// One item is in work at a time; in_stall is high while a run is in progress.
// A run that executes 2^20 instructions without stopping gives no result and
// the next run item continues where it left off.
// Output channel (out_valid/out_stall/out_data): a result sits in an output
// register until taken; loads are still accepted while it waits, and a run
// that finishes while the receiver stalls holds until the register frees.
// After reset, the first tape cell is zeroed before items are accepted.
// ----------------------------------------------------------------------------
`include "tape_machine_interpreter_unit_assert.svh"

module tape_machine_interpreter_unit
  import tmi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      res_valid;
  logic      res_take;
  out_item_t res;

  tmi_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .res_valid(res_valid), .res(res), .res_take(res_take)
  );

  tmi_oreg u_oreg (
    .clk(clk), .rst(rst),
    .res_valid(res_valid), .res(res), .res_take(res_take),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  `TMI_ASSERT_NOW(a_take_needs_valid, res_take, res_valid)
  `TMI_ASSERT_NEXT(a_pending_holds, res_valid && !res_take, res_valid && $stable(res))
  `TMI_ASSERT_NEXT(a_run_busy, in_valid && !in_stall && in_data.req_type == REQ_RUN,
                   in_stall)
  `TMI_ASSERT_NEXT(a_take_fills, res_take, out_valid && out_data == $past(res))

endmodule
